// ===== design/ctt1_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt1_pkg
// Shared types and constants for the type-1 cosine transform unit.
// ----------------------------------------------------------------------------
package ctt1_pkg;

    localparam int SAMPLE_W = 24;
    localparam int CNT_W    = 11;
    localparam int PHASE_W  = 24;
    localparam int INDEX_W  = 10;
    localparam int RESULT_W = 32;
    localparam int COS_W    = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    // sine polynomial coefficients, Q30
    localparam logic [31:0] SIN_C0  = 32'd1686629713;
    localparam logic [31:0] SIN_C1  = 32'd693598668;
    localparam logic [31:0] SIN_C2  = 32'd85569306;
    localparam logic [31:0] SIN_C3  = 32'd5026994;
    localparam logic [31:0] SIN_C4  = 32'd172272;
    localparam logic [33:0] ONE_Q30 = 34'd1073741824;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_FWD   = 2'd1;
    localparam logic [1:0] FUNC_INV   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SCALE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_END0,
        ST_ENDH,
        ST_CSTART,
        ST_CWAIT,
        ST_ACC,
        ST_MAG,
        ST_RND,
        ST_MULLO,
        ST_MULHI,
        ST_INVRND,
        ST_SAT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [PHASE_W-1:0]    angle;
    } t_cos_req;

    typedef struct packed {
        logic                    done;
        logic signed [COS_W-1:0] value;
    } t_cos_rsp;

    // coefficient subtracted from at each Horner step
    function automatic logic [31:0] horner_coef(input logic [2:0] step);
        logic [31:0] c;
        case (step)
            3'd1:    c = SIN_C3;
            3'd2:    c = SIN_C2;
            3'd3:    c = SIN_C1;
            3'd4:    c = SIN_C0;
            default: c = SIN_C4;
        endcase
        return c;
    endfunction

endpackage

// ===== design/ctt1_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt1_req_if / ctt1_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ctt1_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           func;
    logic [ctt1_pkg::INDEX_W-1:0]         index;
    logic signed [ctt1_pkg::SAMPLE_W-1:0] value;

    modport source (output valid, func, index, value, input ready);
    modport sink   (input valid, func, index, value, output ready);
endinterface

interface ctt1_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ctt1_pkg::RESULT_W-1:0] result;
    logic                                 overflow;

    modport source (output valid, result, overflow, input ready);
    modport sink   (input valid, result, overflow, output ready);
endinterface

// ===== design/ctt1_cos_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt1_cos_unit
// Iterative Q16 cosine: quadrant fold, then Horner polynomial on one
// shared 32x32 multiplier, one product per cycle while busy; the done
// flag is registered after the last step.
// ----------------------------------------------------------------------------
module ctt1_cos_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctt1_pkg::t_cos_req i_req,
    output ctt1_pkg::t_cos_rsp o_rsp
);

    logic        r_busy, n_busy;
    logic [2:0]  r_step, n_step;
    logic [31:0] r_z, n_z;
    logic [31:0] r_z2, n_z2;
    logic [31:0] r_t, n_t;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic signed [ctt1_pkg::COS_W-1:0] r_val, n_val;

    logic [23:0] p;
    logic [21:0] x;
    logic [22:0] zq;
    logic [31:0] op_a, op_b;
    logic [63:0] prod;
    logic [33:0] p30;
    logic [33:0] s_clamp;
    logic [16:0] s_rnd;

    always_comb begin
        p    = i_req.angle + 24'h400000;
        x    = p[21:0];
        zq   = p[22] ? (23'h400000 - {1'b0, x}) : {1'b0, x};

        op_a = (r_step == 3'd0) ? r_z : r_t;
        op_b = (r_step == 3'd0 || r_step == 3'd5) ? r_z : r_z2;
        prod = 64'(op_a) * 64'(op_b);
        p30  = prod[63:30];

        s_clamp = (p30 > ctt1_pkg::ONE_Q30) ? ctt1_pkg::ONE_Q30 : p30;
        s_rnd   = 17'((s_clamp + 34'd8192) >> 14);

        n_busy = r_busy;
        n_step = r_step;
        n_z    = r_z;
        n_z2   = r_z2;
        n_t    = r_t;
        n_neg  = r_neg;
        n_done = 1'b0;
        n_val  = r_val;

        if (!r_busy) begin
            if (i_req.start) begin
                n_busy = 1'b1;
                n_step = 3'd0;
                n_z    = {1'b0, zq, 8'd0};
                n_neg  = p[23];
            end
        end else begin
            n_step = r_step + 3'd1;
            case (r_step)
                3'd0: begin
                    n_z2 = p30[31:0];
                    n_t  = ctt1_pkg::SIN_C4;
                end
                3'd1, 3'd2, 3'd3, 3'd4: begin
                    n_t = ctt1_pkg::horner_coef(r_step) - p30[31:0];
                end
                default: begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                    n_val  = r_neg ? -$signed({1'b0, s_rnd}) : $signed({1'b0, s_rnd});
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_z   <= n_z;
        r_z2  <= n_z2;
        r_t   <= n_t;
        r_neg <= n_neg;
        r_val <= n_val;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_val;

endmodule

// ===== design/cosine_transform_type1_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_transform_type1_unit
// Type-1 cosine transform of a stored trace, one output per read request.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    func, index, value
//  o_rsp     out  valid/ready    result, overflow
//  i_cfg_*   in   write enable   index, data (no back-pressure)
//
//  A write returns no transaction; the block stays idle.
//  A read holds the block busy until its result is registered; the loop
//  runs j from 1 to L - 1, L = min(half_length, sample_count).
//  Each sample runs cosine start, six products in the shared multiplier,
//  the done flag and the multiply-accumulate.
//  Inverse reads add two partial products and a rounding step.
//  Reset (synchronous, active low) clears control state and loads register
//  defaults; sample memory holds garbage until written.
//  i_req.ready is high only when idle; a finished result waiting in the
//  output register does not block a new request, but a second finished
//  result stalls until the first transaction completes.
// ----------------------------------------------------------------------------
module cosine_transform_type1_unit #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ctt1_req_if.sink                           i_req,
    ctt1_rsp_if.source                         o_rsp,
    input  logic                               i_cfg_we,
    input  logic [ctt1_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ctt1_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int ACC_W = 56;
    localparam int SW    = ctt1_pkg::SAMPLE_W;
    localparam int CW    = ctt1_pkg::CNT_W;

    // configuration registers
    logic [CW-1:0]  r_count, r_half;
    logic [23:0]    r_phase, r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 11'd1024;
            r_half  <= 11'd1024;
            r_phase <= 24'd8192;
            r_scale <= 24'd8192;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ctt1_pkg::CFG_SAMPLE_COUNT:  r_count <= i_cfg_data[CW-1:0];
                ctt1_pkg::CFG_HALF_LENGTH:   r_half  <= i_cfg_data[CW-1:0];
                ctt1_pkg::CFG_PHASE_STEP:    r_phase <= i_cfg_data;
                ctt1_pkg::CFG_INVERSE_SCALE: r_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective count and loop limit
    logic [CW-1:0] count_eff, limit;
    assign count_eff = (32'(r_count) > MAX_SAMPLES) ? CW'(MAX_SAMPLES) : r_count;
    assign limit     = (r_half < count_eff) ? r_half : count_eff;

    // sample memory: one write port (idle writes), one registered read port
    logic [SW-1:0] r_mem [MAX_SAMPLES];
    logic [SW-1:0] r_rdata;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[AW'(i_req.index)] <= i_req.value;
        r_rdata <= r_mem[rd_addr];
    end

    // sequencer state
    ctt1_pkg::t_state r_state, n_state;
    logic                       r_inv, n_inv;
    logic [ctt1_pkg::INDEX_W-1:0] r_idx, n_idx;
    logic [23:0]                r_step, n_step;
    logic [23:0]                r_ang, n_ang;
    logic [CW-1:0]              r_j, n_j;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic signed [41:0]         r_mac, n_mac;
    logic [ACC_W-1:0]           r_mag, n_mag;
    logic                       r_neg, n_neg;
    logic [63:0]                r_prod, n_prod;
    logic                       r_out_valid, n_out_valid;
    logic signed [31:0]         r_result, n_result;
    logic                       r_ovf, n_ovf;

    ctt1_pkg::t_cos_req cos_req;
    ctt1_pkg::t_cos_rsp cos_rsp;

    ctt1_cos_unit u_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cos_req),
        .o_rsp   (cos_rsp)
    );

    logic signed [ACC_W-1:0] samp_term;
    logic [33:0]             step_prod;
    logic [CW-1:0]           j_inc;

    always_comb begin
        samp_term = ACC_W'($signed(r_rdata)) <<< 16;
        step_prod = 34'(r_idx) * 34'(r_phase);
        j_inc     = r_j + 11'd1;

        n_state     = r_state;
        n_inv       = r_inv;
        n_idx       = r_idx;
        n_step      = r_step;
        n_ang       = r_ang;
        n_j         = r_j;
        n_acc       = r_acc;
        n_mac       = r_mac;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_prod      = r_prod;
        n_result    = r_result;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !o_rsp.ready;
        rd_addr     = AW'(r_j);
        mem_we      = 1'b0;
        cos_req     = '{start: 1'b0, angle: r_ang};
        i_req.ready = (r_state == ctt1_pkg::ST_IDLE);

        case (r_state)
            ctt1_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_idx = i_req.index;
                    n_inv = (i_req.func == ctt1_pkg::FUNC_INV);
                    if (i_req.func == ctt1_pkg::FUNC_WRITE)
                        mem_we = (32'(i_req.index) < MAX_SAMPLES);
                    else if (i_req.func == ctt1_pkg::FUNC_FWD ||
                             i_req.func == ctt1_pkg::FUNC_INV)
                        n_state = ctt1_pkg::ST_START;
                end
            end
            ctt1_pkg::ST_START: begin
                rd_addr = '0;
                n_step  = step_prod[23:0];
                n_state = ctt1_pkg::ST_END0;
            end
            ctt1_pkg::ST_END0: begin
                rd_addr = AW'(r_half);
                n_acc   = (count_eff != '0) ? samp_term : '0;
                n_state = ctt1_pkg::ST_ENDH;
            end
            ctt1_pkg::ST_ENDH: begin
                if (r_half < count_eff)
                    n_acc = r_idx[0] ? (r_acc - samp_term) : (r_acc + samp_term);
                n_ang   = r_step;
                n_j     = 11'd1;
                n_state = (limit > 11'd1) ? ctt1_pkg::ST_CSTART : ctt1_pkg::ST_MAG;
            end
            ctt1_pkg::ST_CSTART: begin
                cos_req.start = 1'b1;
                n_state       = ctt1_pkg::ST_CWAIT;
            end
            ctt1_pkg::ST_CWAIT: begin
                if (cos_rsp.done) begin
                    n_mac   = $signed(r_rdata) * cos_rsp.value;
                    n_state = ctt1_pkg::ST_ACC;
                end
            end
            ctt1_pkg::ST_ACC: begin
                n_acc   = r_acc + (ACC_W'(r_mac) <<< 1);
                n_j     = j_inc;
                n_ang   = r_ang + r_step;
                n_state = (j_inc < limit) ? ctt1_pkg::ST_CSTART : ctt1_pkg::ST_MAG;
            end
            ctt1_pkg::ST_MAG: begin
                n_neg   = r_acc[ACC_W-1];
                n_mag   = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
                n_state = ctt1_pkg::ST_RND;
            end
            ctt1_pkg::ST_RND: begin
                // round half away from zero on the magnitude
                n_mag   = (r_mag + ACC_W'(32768)) >> 16;
                n_state = r_inv ? ctt1_pkg::ST_MULLO : ctt1_pkg::ST_SAT;
            end
            ctt1_pkg::ST_MULLO: begin
                n_prod  = 64'(r_mag[19:0]) * 64'(r_scale);
                n_state = ctt1_pkg::ST_MULHI;
            end
            ctt1_pkg::ST_MULHI: begin
                n_prod  = r_prod + ((64'(r_mag[39:20]) * 64'(r_scale)) << 20);
                n_state = ctt1_pkg::ST_INVRND;
            end
            ctt1_pkg::ST_INVRND: begin
                n_mag   = ACC_W'((r_prod + 64'd8388608) >> 24);
                n_state = ctt1_pkg::ST_SAT;
            end
            ctt1_pkg::ST_SAT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_state     = ctt1_pkg::ST_IDLE;
                    if (!r_neg) begin
                        n_ovf    = (r_mag > ACC_W'(32'h7FFFFFFF));
                        n_result = n_ovf ? 32'sh7FFFFFFF : $signed(r_mag[31:0]);
                    end else begin
                        n_ovf    = (r_mag > ACC_W'(32'h80000000));
                        n_result = n_ovf ? 32'sh80000000 : -$signed(r_mag[31:0]);
                    end
                end
            end
            default: n_state = ctt1_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ctt1_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_inv    <= n_inv;
        r_idx    <= n_idx;
        r_step   <= n_step;
        r_ang    <= n_ang;
        r_j      <= n_j;
        r_acc    <= n_acc;
        r_mac    <= n_mac;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_prod   <= n_prod;
        r_result <= n_result;
        r_ovf    <= n_ovf;
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.result   = r_result;
    assign o_rsp.overflow = r_ovf;

    // saturation flag only with a clamped value
    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.overflow) |->
        (o_rsp.result == 32'sh7FFFFFFF || o_rsp.result == 32'sh80000000))
        else $error("overflow without clamped result");

    // loop index stays inside the sample range
    a_j_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ctt1_pkg::ST_CSTART) |-> (r_j < limit && r_j != '0))
        else $error("loop index out of range");

    // a read request takes the block busy
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready &&
         (i_req.func == ctt1_pkg::FUNC_FWD || i_req.func == ctt1_pkg::FUNC_INV))
        |=> !i_req.ready)
        else $error("ready after read request");

    // cosine result only arrives while waiting for it
    a_cos_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cos_rsp.done |-> (r_state == ctt1_pkg::ST_CWAIT))
        else $error("cosine done outside wait");

endmodule
